// File: rtl/tws_pkg.sv
// Package for the three-wire SPI register master.
// Holds the command codes, frame constants and the state/result structs.
// No dependencies.
package tws_pkg;

  localparam int unsigned HALF_W   = 16;
  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ADDR_W   = 7;
  localparam int unsigned CNT_W    = 5;

  // Command codes on in_func
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [HALF_W-1:0] HALF_RESET = 16'd50;
  localparam logic [CNT_W-1:0]  FRAME_BITS = 5'd16;
  localparam logic [CNT_W-1:0]  RX_BITS    = 5'd8;

  typedef struct packed {
    logic               active;
    logic               is_read;
    logic [CNT_W-1:0]   bits_left;
    logic               phase_high;
    logic [HALF_W-1:0]  tick_count;
    logic [FRAME_W-1:0] shift_out;
    logic [BYTE_W-1:0]  shift_in;
  } tws_state_t;

  typedef struct packed {
    logic              sclk;
    logic              ncs;
    logic              data_out;
    logic              data_oe;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
  } tws_result_t;

endpackage

// File: rtl/tws_step.sv
// One tick of the SPI bit-timing sequencer: next state and pin levels.
// Purely combinational; depends on tws_pkg.
module tws_step
  import tws_pkg::*;
(
  input  tws_state_t         state_i,
  input  logic [1:0]         func,
  input  logic [ADDR_W-1:0]  reg_addr,
  input  logic [BYTE_W-1:0]  write_byte,
  input  logic               data_in,
  input  logic [HALF_W-1:0]  half_period_ticks,
  output tws_state_t         state_o,
  output tws_result_t        result_o
);

  logic [HALF_W-1:0] half;
  logic [HALF_W:0]   tick_inc;
  logic              receiving;
  logic              done;
  logic [BYTE_W-1:0] rdata;

  always_comb begin
    state_o  = state_i;
    done     = 1'b0;
    rdata    = '0;
    // a zero half period behaves as one tick
    half     = (half_period_ticks == '0) ? {{(HALF_W-1){1'b0}}, 1'b1} : half_period_ticks;
    tick_inc = {1'b0, state_i.tick_count} + {{HALF_W{1'b0}}, 1'b1};

    if (!state_i.active) begin
      if (func == FUNC_WRITE || func == FUNC_READ) begin
        state_o.active     = 1'b1;
        state_o.is_read    = (func == FUNC_READ);
        state_o.bits_left  = FRAME_BITS;
        state_o.phase_high = 1'b0;
        state_o.tick_count = '0;
        state_o.shift_in   = '0;
        if (func == FUNC_READ) begin
          state_o.shift_out = {1'b0, reg_addr, {BYTE_W{1'b0}}};
        end else begin
          state_o.shift_out = {1'b1, reg_addr, write_byte};
        end
      end
    end else if (tick_inc >= {1'b0, half}) begin
      state_o.tick_count = '0;
      if (!state_i.phase_high) begin
        state_o.phase_high = 1'b1;
      end else begin
        // sample the read bit at the end of its high half
        if (state_i.is_read && state_i.bits_left <= RX_BITS) begin
          state_o.shift_in = {state_i.shift_in[BYTE_W-2:0], data_in};
        end
        state_o.bits_left = state_i.bits_left - {{(CNT_W-1){1'b0}}, 1'b1};
        if (state_o.bits_left == '0) begin
          state_o.active = 1'b0;
          done           = 1'b1;
          if (state_i.is_read) begin
            rdata = state_o.shift_in;
          end
        end else begin
          state_o.phase_high = 1'b0;
          state_o.shift_out  = {state_i.shift_out[FRAME_W-2:0], 1'b0};
        end
      end
    end else begin
      state_o.tick_count = tick_inc[HALF_W-1:0];
    end

    receiving = state_o.active && state_o.is_read && (state_o.bits_left <= RX_BITS);

    result_o.sclk      = state_o.active ? state_o.phase_high : 1'b1;
    result_o.ncs       = !state_o.active;
    result_o.data_out  = (state_o.active && !receiving) ? state_o.shift_out[FRAME_W-1] : 1'b0;
    result_o.data_oe   = !receiving;
    result_o.busy_res  = state_o.active;
    result_o.done_res  = done;
    result_o.read_data = rdata;
  end

endmodule

// File: rtl/three_wire_spi_register_master_top.sv
// Top level of the three-wire SPI register master (mode 3).
// Holds the sequencer state, the half-period register and the result register;
// depends on tws_pkg and tws_step.
//
//  channel | direction | handshake           | beat carries
//  --------+-----------+---------------------+-------------------------------------
//  in_     | input     | in_valid/in_ready   | func, reg_addr, write_byte, data_in
//  out_    | output    | out_valid/out_ready | sclk, ncs, data_out, data_oe,
//          |           |                     | busy_res, done_res, read_data
//  cfg_    | input     | cfg_valid/cfg_ready | half_period_ticks (16 bits)
//
// Every input beat is one tick of the sequencer and yields exactly one output beat.
// The tick is computed combinationally by tws_step and lands in the result register,
// so one beat is accepted per clock as long as out_ready keeps up.
// in_ready is high while the result register is empty or being drained this cycle;
// a stalled output holds its beat and stops further input.
// Synchronous active-low reset returns the sequencer to idle (sclk/ncs high) with a half period of 50.
// cfg_ready is always high; the half period register is written on any cfg beat.
module three_wire_spi_register_master_top
  import tws_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [HALF_W-1:0]  cfg_data,
  // input tick channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [ADDR_W-1:0]  in_reg_addr,
  input  logic [BYTE_W-1:0]  in_write_byte,
  input  logic               in_data_in,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_sclk,
  output logic               out_ncs,
  output logic               out_data_out,
  output logic               out_data_oe,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic [BYTE_W-1:0]  out_read_data
);

  tws_state_t        state_r;
  tws_state_t        state_nxt;
  tws_result_t       result_r;
  tws_result_t       result_nxt;
  logic              out_valid_r;
  logic [HALF_W-1:0] half_r;
  logic              in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  tws_step u_step (
    .state_i           (state_r),
    .func              (in_func),
    .reg_addr          (in_reg_addr),
    .write_byte        (in_write_byte),
    .data_in           (in_data_in),
    .half_period_ticks (half_r),
    .state_o           (state_nxt),
    .result_o          (result_nxt)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_r <= cfg_data;
    end
  end

  // sequencer state: advance only on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{active: 1'b0, is_read: 1'b0, bits_left: '0, phase_high: 1'b1,
                   tick_count: '0, shift_out: '0, shift_in: '0};
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // result register: load on accept, drop the valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sclk      = result_r.sclk;
  assign out_ncs       = result_r.ncs;
  assign out_data_out  = result_r.data_out;
  assign out_data_oe   = result_r.data_oe;
  assign out_busy_res  = result_r.busy_res;
  assign out_done_res  = result_r.done_res;
  assign out_read_data = result_r.read_data;

endmodule
